// File: rtl/wspf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspf_pkg: shared types and constants of the windowed-sum peak finder
// Field widths, register indexes, back-end states and the result beat.
// ----------------------------------------------------------------------------
package wspf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int THRESH_W    = 22;
    localparam int HW_CFG_W    = 5;
    localparam int INDEX_W     = 12;
    localparam int SUM_W       = 22;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_IDX_W   = 1;
    localparam int CHUNK       = 8;   // delay-line taps summed per cycle
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SUM_W-1:0]     SUM_MAX          = '1;
    localparam logic [HW_CFG_W-1:0]  HALF_WIDTH_RESET = 5'd1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SUM,
        ST_TRACK,
        ST_CLOSE,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        logic               has_peak;
        logic [INDEX_W-1:0] peak_index;
        logic [SUM_W-1:0]   peak_sum;
        logic               end_of_profile;
    } t_result;

endpackage

// File: rtl/wspf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspf_queue: small job queue between front and back end
// Register-based FIFO; combinational read of the head entry.
// ----------------------------------------------------------------------------
module wspf_queue import wspf_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        f_inc = (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (32'(r_cnt) == DEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (32'(r_cnt) != DEPTH))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue pop while empty");

endmodule

// File: rtl/wspf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspf_front: input side of the peak finder
// Takes sample beats, tags each with its profile position and half width,
// and pushes it as a job into the queue.
// ----------------------------------------------------------------------------
module wspf_front import wspf_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 16,
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_LENGTH     = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [SAMPLE_W-1:0]                  i_sample,
    input  logic                                 i_final_sample,
    input  logic [$clog2(MAX_HALF_WIDTH+1)-1:0]  i_hw,
    input  logic                                 i_q_full,
    output logic                                 o_q_push,
    output logic [((SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W)
                  + 1 + $clog2(MAX_LENGTH + MAX_HALF_WIDTH)
                  + $clog2(MAX_HALF_WIDTH+1) - 1:0] o_q_data
);

    localparam int SMP_W    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int SEEN_SAT = MAX_LENGTH + MAX_HALF_WIDTH;
    localparam int N_W      = $clog2(SEEN_SAT);
    localparam int SEEN_W   = $clog2(SEEN_SAT + 1);

    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    logic [N_W-1:0]    pos;

    // position of this sample; saturates so late centres report the last index
    assign pos = (32'(r_seen) < SEEN_SAT - 1) ? N_W'(r_seen) : N_W'(SEEN_SAT - 1);

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign o_q_data   = {SMP_W'(i_sample), i_final_sample, pos, i_hw};

    assign n_seen = i_final_sample ? '0 : SEEN_W'(pos) + SEEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (o_q_push) begin
            r_seen <= n_seen;
        end
    end

endmodule

// File: rtl/wspf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wspf_back: window sums, run tracking and result output
// Per job: shift the delay line, sum each due window CHUNK taps a cycle,
// track the open run, hold the newest result one step for the end mark.
// ----------------------------------------------------------------------------
module wspf_back import wspf_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 16,
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_LENGTH     = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  logic [((SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W)
                  + 1 + $clog2(MAX_LENGTH + MAX_HALF_WIDTH)
                  + $clog2(MAX_HALF_WIDTH+1) - 1:0] i_job,
    output logic                  o_job_pop,
    input  logic [THRESH_W-1:0]   i_threshold,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_result               o_result
);

    localparam int SMP_W      = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int LINE_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int SCR_D      = ((LINE_DEPTH + CHUNK - 1) / CHUNK) * CHUNK;
    localparam int HW_W       = $clog2(MAX_HALF_WIDTH + 1);
    localparam int N_W        = $clog2(MAX_LENGTH + MAX_HALF_WIDTH);
    localparam int L_W        = $clog2(LINE_DEPTH);
    localparam int REM_W      = $clog2(SCR_D + 1);
    localparam int ACC_W      = SMP_W + $clog2(SCR_D + 1);
    localparam int IDX_W      = $clog2(MAX_LENGTH);

    localparam t_result BARE_END = '{has_peak: 1'b0, peak_index: '0, peak_sum: '0,
                                     end_of_profile: 1'b1};

    // job fields
    logic [SMP_W-1:0] job_sample;
    logic             job_last;
    logic [N_W-1:0]   job_n;
    logic [HW_W-1:0]  job_hw;

    assign {job_sample, job_last, job_n, job_hw} = i_job;

    t_back_state       r_state, n_state;
    logic [SMP_W-1:0]  r_line [LINE_DEPTH];
    logic [SMP_W-1:0]  r_scr  [SCR_D];
    logic [ACC_W-1:0]  r_acc;
    logic [REM_W-1:0]  r_rem;
    logic [N_W-1:0]    r_n;
    logic [HW_W-1:0]   r_hw;
    logic [HW_W-1:0]   r_d;
    logic              r_last;
    logic              r_in_run;
    logic [IDX_W-1:0]  r_best_idx;
    logic [SUM_W-1:0]  r_best_sum;
    logic              r_p_valid;
    t_result           r_p;
    logic              r_o_valid, n_o_valid;
    t_result           r_o;

    logic              pop, load_scr, do_sum, take, push, deliver, close_run, step_d;
    logic              o_free, push_ok, o_load;
    logic              more, centre_ok, above, closes;
    t_back_state       after;
    logic [L_W-1:0]    dh, lim;
    logic [N_W-1:0]    centre;
    logic [IDX_W-1:0]  idx;
    logic [ACC_W-1:0]  chunk_sum;
    logic [SUM_W-1:0]  win_sum;
    t_result           run_res;

    // window of centre n-d spans taps 0 .. min(d+hw, n)
    assign dh        = L_W'(r_d) + L_W'(r_hw);
    assign lim       = (32'(r_n) < 32'(dh)) ? L_W'(r_n) : dh;
    assign centre_ok = (32'(r_d) <= 32'(r_n));
    assign centre    = r_n - N_W'(r_d);
    assign idx       = (32'(centre) < MAX_LENGTH) ? IDX_W'(centre) : IDX_W'(MAX_LENGTH - 1);

    always_comb begin
        chunk_sum = '0;
        for (int i = 0; i < CHUNK; i++) begin
            if (REM_W'(i) < r_rem) begin
                chunk_sum = chunk_sum + ACC_W'(r_scr[i]);
            end
        end
    end

    assign win_sum = (32'(r_acc) > 32'(SUM_MAX)) ? SUM_MAX : SUM_W'(r_acc);
    assign above   = (win_sum > i_threshold);
    assign closes  = !above && r_in_run;
    assign run_res = '{has_peak: 1'b1, peak_index: INDEX_W'(r_best_idx),
                       peak_sum: r_best_sum, end_of_profile: 1'b0};

    assign more  = r_last && (r_d != '0);
    assign after = more ? ST_START : (r_last ? ST_CLOSE : ST_DONE);

    assign o_free  = !r_o_valid || !i_out_stall;
    assign push_ok = !r_p_valid || o_free;
    assign o_load  = (push && r_p_valid) || (deliver && (r_p_valid || r_last));

    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        load_scr  = 1'b0;
        do_sum    = 1'b0;
        take      = 1'b0;
        push      = 1'b0;
        deliver   = 1'b0;
        close_run = 1'b0;
        step_d    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    pop     = 1'b1;
                    n_state = ST_START;
                end
            end
            ST_START: begin
                if (centre_ok) begin
                    load_scr = 1'b1;
                    n_state  = ST_SUM;
                end else begin
                    step_d  = more;
                    n_state = after;
                end
            end
            ST_SUM: begin
                do_sum = 1'b1;
                if (r_rem <= REM_W'(CHUNK)) begin
                    n_state = ST_TRACK;
                end
            end
            ST_TRACK: begin
                if (!closes || push_ok) begin
                    take    = 1'b1;
                    push    = closes;
                    step_d  = more;
                    n_state = after;
                end
            end
            ST_CLOSE: begin
                if (!r_in_run || push_ok) begin
                    push      = r_in_run;
                    close_run = 1'b1;
                    n_state   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!(r_p_valid || r_last) || o_free) begin
                    deliver = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_job_pop = pop;

    always_comb begin
        n_o_valid = r_o_valid;
        if (o_load) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_in_run  <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (push) begin
                r_p_valid <= 1'b1;
            end else if (deliver) begin
                r_p_valid <= 1'b0;
            end
            if (take) begin
                r_in_run <= above;
            end else if (close_run) begin
                r_in_run <= 1'b0;
            end
        end
    end

    // job, delay line and window accumulator
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_line[0] <= job_sample;
            for (int k = 1; k < LINE_DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
            r_n    <= job_n;
            r_hw   <= job_hw;
            r_d    <= job_hw;
            r_last <= job_last;
        end
        if (step_d) begin
            r_d <= r_d - HW_W'(1);
        end
        if (load_scr) begin
            for (int i = 0; i < LINE_DEPTH; i++) begin
                r_scr[i] <= r_line[i];
            end
            for (int i = LINE_DEPTH; i < SCR_D; i++) begin
                r_scr[i] <= '0;
            end
            r_acc <= '0;
            r_rem <= REM_W'(lim) + REM_W'(1);
        end else if (do_sum) begin
            for (int i = 0; i < SCR_D - CHUNK; i++) begin
                r_scr[i] <= r_scr[i+CHUNK];
            end
            for (int i = SCR_D - CHUNK; i < SCR_D; i++) begin
                r_scr[i] <= '0;
            end
            r_acc <= r_acc + chunk_sum;
            r_rem <= r_rem - REM_W'(CHUNK);
        end
    end

    // run tracker: first largest sum of the open run
    always_ff @(posedge i_clk) begin
        if (take && above && (!r_in_run || win_sum > r_best_sum)) begin
            r_best_idx <= idx;
            r_best_sum <= win_sum;
        end
    end

    // held result and output register
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_p <= run_res;
        end
        if (push && r_p_valid) begin
            r_o <= r_p;
        end else if (deliver && r_p_valid) begin
            r_o <= '{has_peak: r_p.has_peak, peak_index: r_p.peak_index,
                     peak_sum: r_p.peak_sum, end_of_profile: r_last};
        end else if (deliver && r_last) begin
            r_o <= BARE_END;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_result    = r_o;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |-> o_free)
        else $error("output register overwritten while stalled");

    a_sum_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> (r_rem != '0))
        else $error("window sum with no taps left");

    a_d_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_d <= r_hw))
        else $error("centre offset beyond half width");

endmodule

// File: rtl/windowed_sum_peak_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sum_peak_finder: moving-sum threshold peak detector
// Streams a profile, forms a cut-off window sum per index, and reports the
// first largest sum of every run of indices above the threshold.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-----------------------------------
//  in       | i_in_valid / o_in_stall          | i_sample, i_final_sample
//  out      | o_out_valid / i_out_stall        | o_has_peak, o_peak_index,
//           |                                  | o_peak_sum, o_end_of_profile
//  cfg      | i_cfg_we (write only)            | i_cfg_idx, i_cfg_data
//
//  Back end: each sample sums the window of its newly due centre over
//    min(2*hw, n) + 1 taps, n being the samples already seen in this profile
//    and hw the clamped half width; no sum while that centre is not yet due
//    (n < hw). The final sample also sums each tail centre at offset d below
//    hw over min(d+hw, n) + 1 taps, skips one not yet due, then closes the run.
//  The window accumulator adds 8 delay-line taps a cycle and is shared by all
//    centres.
//  A two-beat queue lets the front take samples while the back end works.
//  Reset is synchronous and single-cycle; no clearing pass.
//  Output stalls hold the back end only when a new result has no room.
//
module windowed_sum_peak_finder import wspf_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 16,
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_LENGTH     = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_final_sample,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_has_peak,
    output logic [INDEX_W-1:0]    o_peak_index,
    output logic [SUM_W-1:0]      o_peak_sum,
    output logic                  o_end_of_profile,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SMP_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int HW_W   = $clog2(MAX_HALF_WIDTH + 1);
    localparam int N_W    = $clog2(MAX_LENGTH + MAX_HALF_WIDTH);
    localparam int JOB_W  = SMP_W + 1 + N_W + HW_W;

    // configuration registers; the user must write them only while the block is idle (not enforced here)
    logic [THRESH_W-1:0] r_threshold;
    logic [HW_CFG_W-1:0] r_half_width;
    logic [HW_W-1:0]     hw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_half_width <= HALF_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD:  r_threshold  <= THRESH_W'(i_cfg_data);
                REG_HALF_WIDTH: r_half_width <= HW_CFG_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // half widths above the built window act as the largest one
    assign hw = (32'(r_half_width) > MAX_HALF_WIDTH) ? HW_W'(MAX_HALF_WIDTH)
                                                      : HW_W'(r_half_width);

    logic             q_push, q_full, q_pop, q_valid;
    logic [JOB_W-1:0] q_wdata, q_rdata;
    t_result          result;

    wspf_front #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_LENGTH     (MAX_LENGTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_final_sample (i_final_sample),
        .i_hw           (hw),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    wspf_queue #(
        .WIDTH   (JOB_W),
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    wspf_back #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_LENGTH     (MAX_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_rdata),
        .o_job_pop   (q_pop),
        .i_threshold (r_threshold),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_has_peak       = result.has_peak;
    assign o_peak_index     = result.peak_index;
    assign o_peak_sum       = result.peak_sum;
    assign o_end_of_profile = result.end_of_profile;

endmodule
